### rtl/ymsq_pkg.sv
// shared types and constants for the yearly mean stripe quantizer
// no dependencies; imported by ymsq_alu and the top level
package ymsq_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MEAN_W     = 16;
    localparam int SUM_W      = 20;
    localparam int ALU_W      = 21;
    localparam int BIN_W      = 3;
    localparam int IDX_W      = 6;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // 1.0 in q12.8 at the ALU width
    localparam logic signed [ALU_W-1:0] ONE_Q8 = ALU_W'(256);

    typedef enum logic
    {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed
    {
        logic neg;
        logic zero;
    } alu_flags_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_ACC,
        ST_DIV_ABS,
        ST_DIV_MUL,
        ST_DIV_SIGN,
        ST_MIN,
        ST_MAX,
        ST_RANGE,
        ST_RANGE_ONE,
        ST_RD,
        ST_DIFF,
        ST_CMP,
        ST_ADD,
        ST_OUT
    } state_t;

endpackage

### rtl/ymsq_ram.sv
// generic single write port ram with registered read
// no dependencies
module ymsq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/ymsq_alu.sv
// shared add / subtract unit with sign and zero flags
// depends on ymsq_pkg
module ymsq_alu
    import ymsq_pkg::*;
(
    input  alu_op_t                  op,
    input  logic signed [ALU_W-1:0]  a,
    input  logic signed [ALU_W-1:0]  b,
    output logic signed [ALU_W-1:0]  res,
    output alu_flags_t               flags
);

    always_comb
    begin
        case (op)
            ALU_ADD: res = a + b;
            ALU_SUB: res = a - b;
            default: res = a + b;
        endcase
        flags.neg  = res[ALU_W-1];
        flags.zero = (res == '0);
    end

endmodule

### rtl/year_mean_stripe_quantizer.sv
// channel   dir  signals                        item
// s_axis    in   tvalid tready tdata tlast      one monthly sample, tlast marks end of run
// m_axis    out  tvalid tready tdata tlast      one classified year, tlast on the final year
//
// a sample is added to the running sum; one that closes a year is then divided (magnitude
// times the reciprocal of MONTHS_PER_YEAR, sign fix), then min/max update and store write,
// which are skipped if the store is full; emission per year reads the store, then runs the
// compare/add steps and presents the output; one adder does the add/subtract work, the
// year store has one read port; input is not ready while a sample or the emission walk is in progress
// asynchronous active-low reset clears the run; output stalls hold the result in place
//
// top level of the yearly mean stripe quantizer
// depends on ymsq_pkg, ymsq_alu, ymsq_ram
module year_mean_stripe_quantizer
    import ymsq_pkg::*;
#(
    parameter int MAX_YEARS       = 64,
    parameter int MONTHS_PER_YEAR = 12,
    parameter int NUM_BINS        = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample[15:0]
    input  logic                  s_axis_tlast,   // last_sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // year_index[5:0], year_mean[21:6], bin[24:22]
    output logic                  m_axis_tlast    // last_year
);

    localparam int CNT_W   = $clog2(MAX_YEARS + 1);
    localparam int ADDR_W  = MAX_YEARS > 1 ? $clog2(MAX_YEARS) : 1;
    localparam int MONTH_W = $clog2(MONTHS_PER_YEAR + 1);

    // reciprocal of the divisor, exact for dividend magnitudes below 2^(SUM_W-1)
    localparam int DIV_L     = $clog2(MONTHS_PER_YEAR);
    localparam int DIV_SHIFT = SUM_W - 1 + DIV_L;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = DIV_SHIFT + SUM_W;

    localparam logic [RECIP_W-1:0]      RECIP_C  =
        RECIP_W'((1 << DIV_SHIFT) / MONTHS_PER_YEAR + 1);
    localparam logic signed [ALU_W-1:0] BINS_C   = ALU_W'(NUM_BINS);
    localparam logic [BIN_W-1:0]        LAST_BIN = BIN_W'(NUM_BINS - 1);
    localparam logic [MONTH_W-1:0]      MONTHS_C = MONTH_W'(MONTHS_PER_YEAR);
    localparam logic [CNT_W-1:0]        YEARS_C  = CNT_W'(MAX_YEARS);

    state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                       last_reg, last_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [MONTH_W-1:0]         month_reg, month_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [MEAN_W-1:0]   min_reg, min_next;
    logic signed [MEAN_W-1:0]   max_reg, max_next;
    logic [SUM_W-1:0]           quo_reg, quo_next;
    logic                       neg_reg, neg_next;
    logic signed [MEAN_W-1:0]   mean_reg, mean_next;
    logic signed [ALU_W-1:0]    range_reg, range_next;
    logic signed [ALU_W-1:0]    lhs_reg, lhs_next;
    logic signed [ALU_W-1:0]    acc_reg, acc_next;
    logic [BIN_W-1:0]           j_reg, j_next;
    logic [BIN_W-1:0]           bin_reg, bin_next;
    logic [ADDR_W-1:0]          idx_reg, idx_next;

    alu_op_t                 alu_op;
    logic signed [ALU_W-1:0] alu_a, alu_b, alu_res;
    alu_flags_t              alu_flags;

    logic                    ram_we, ram_re;
    logic [MEAN_W-1:0]       ram_rdata;

    logic [MONTH_W-1:0]      month_inc;
    logic [PROD_W-1:0]       div_prod;
    logic                    close_year;
    logic                    last_out;
    logic                    in_accept, out_accept;

    ymsq_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .flags (alu_flags)
    );

    ymsq_ram #(
        .WIDTH (MEAN_W),
        .DEPTH (MAX_YEARS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (mean_reg),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;
    assign month_inc  = MONTH_W'(month_reg + 1'b1);
    assign close_year = (month_inc == MONTHS_C) || last_reg;
    // magnitude times the rounded-up reciprocal, quotient in the upper bits
    assign div_prod   = PROD_W'(quo_reg) * PROD_W'(RECIP_C);
    assign last_out   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {{(OUT_DATA_W - IDX_W - MEAN_W - BIN_W){1'b0}},
                            bin_reg, mean_reg, IDX_W'(idx_reg)};
    assign m_axis_tlast  = last_out;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (close_year)
                begin
                    state_next = ST_DIV_ABS;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_ABS:
            begin
                state_next = ST_DIV_MUL;
            end
            ST_DIV_MUL:
            begin
                state_next = ST_DIV_SIGN;
            end
            ST_DIV_SIGN:
            begin
                if (count_reg < YEARS_C)
                begin
                    state_next = ST_MIN;
                end
                else if (last_reg)
                begin
                    state_next = ST_RANGE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MIN:
            begin
                state_next = ST_MAX;
            end
            ST_MAX:
            begin
                if (last_reg)
                begin
                    state_next = ST_RANGE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RANGE:
            begin
                state_next = ST_RANGE_ONE;
            end
            ST_RANGE_ONE:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (alu_flags.neg || alu_flags.zero || (j_reg == LAST_BIN))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = ST_CMP;
            end
            ST_OUT:
            begin
                if (out_accept)
                begin
                    if (last_out)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control and register updates
    always_comb
    begin
        sample_next = sample_reg;
        last_next   = last_reg;
        sum_next    = sum_reg;
        month_next  = month_reg;
        count_next  = count_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        quo_next    = quo_reg;
        neg_next    = neg_reg;
        mean_next   = mean_reg;
        range_next  = range_reg;
        lhs_next    = lhs_reg;
        acc_next    = acc_reg;
        j_next      = j_reg;
        bin_next    = bin_reg;
        idx_next    = idx_reg;
        alu_op      = ALU_ADD;
        alu_a       = '0;
        alu_b       = '0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next = $signed(s_axis_tdata[SAMPLE_W-1:0]);
                    last_next   = s_axis_tlast;
                end
            end
            ST_ACC:
            begin
                alu_op     = ALU_ADD;
                alu_a      = ALU_W'(sum_reg);
                alu_b      = ALU_W'(sample_reg);
                sum_next   = alu_res[SUM_W-1:0];
                month_next = month_inc;
            end
            ST_DIV_ABS:
            begin
                // divide the magnitude, fix the sign afterwards
                alu_op     = ALU_SUB;
                alu_a      = '0;
                alu_b      = ALU_W'(sum_reg);
                neg_next   = sum_reg[SUM_W-1];
                quo_next   = sum_reg[SUM_W-1] ? alu_res[SUM_W-1:0] : sum_reg;
                sum_next   = '0;
                month_next = '0;
            end
            ST_DIV_MUL:
            begin
                quo_next = div_prod[DIV_SHIFT +: SUM_W];
            end
            ST_DIV_SIGN:
            begin
                alu_op    = ALU_SUB;
                alu_a     = '0;
                alu_b     = ALU_W'(quo_reg);
                mean_next = neg_reg ? alu_res[MEAN_W-1:0] : quo_reg[MEAN_W-1:0];
            end
            ST_MIN:
            begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(mean_reg);
                alu_b  = ALU_W'(min_reg);
                if (count_reg == '0)
                begin
                    min_next = mean_reg;
                    max_next = mean_reg;
                end
                else if (alu_flags.neg)
                begin
                    min_next = mean_reg;
                end
            end
            ST_MAX:
            begin
                alu_op     = ALU_SUB;
                alu_a      = ALU_W'(max_reg);
                alu_b      = ALU_W'(mean_reg);
                if ((count_reg != '0) && alu_flags.neg)
                begin
                    max_next = mean_reg;
                end
                ram_we     = 1'b1;
                count_next = count_reg + 1'b1;
            end
            ST_RANGE:
            begin
                alu_op     = ALU_SUB;
                alu_a      = ALU_W'(max_reg);
                alu_b      = ALU_W'(min_reg);
                range_next = alu_res;
            end
            ST_RANGE_ONE:
            begin
                alu_op     = ALU_ADD;
                alu_a      = range_reg;
                alu_b      = ONE_Q8;
                range_next = alu_res;
                idx_next   = '0;
            end
            ST_RD:
            begin
                ram_re = 1'b1;
            end
            ST_DIFF:
            begin
                alu_op    = ALU_SUB;
                alu_a     = ALU_W'($signed(ram_rdata));
                alu_b     = ALU_W'(min_reg);
                mean_next = $signed(ram_rdata);
                lhs_next  = ALU_W'(alu_res * BINS_C);
                acc_next  = '0;
                j_next    = '0;
            end
            ST_CMP:
            begin
                // first threshold not below the mean wins
                alu_op   = ALU_SUB;
                alu_a    = lhs_reg;
                alu_b    = acc_reg;
                bin_next = j_reg;
            end
            ST_ADD:
            begin
                alu_op   = ALU_ADD;
                alu_a    = acc_reg;
                alu_b    = range_reg;
                acc_next = alu_res;
                j_next   = j_reg + 1'b1;
            end
            ST_OUT:
            begin
                if (out_accept)
                begin
                    if (last_out)
                    begin
                        count_next = '0;
                        min_next   = '0;
                        max_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            month_reg <= '0;
            count_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            month_reg <= month_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        last_reg   <= last_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
        mean_reg   <= mean_next;
        range_reg  <= range_next;
        lhs_reg    <= lhs_next;
        acc_reg    <= acc_next;
        j_reg      <= j_next;
        bin_reg    <= bin_next;
        idx_reg    <= idx_next;
    end

endmodule
